// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ADTS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ADTS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/adts_pkg.sv =====
// Types, constants and the rate table of the ADTS frame scanner.
// Depends on nothing; imported by every scanner module.
package adts_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int WIN_DEPTH      = 11;
	localparam int FILL_W         = 4;
	localparam int HDR_BYTES      = 8;
	localparam int TAG_HDR_BYTES  = 10;

	localparam int LEN_W   = 13;
	localparam int FCNT_W  = 24;
	localparam int RATE_W  = 4;
	localparam int SRATE_W = 17;
	localparam int TAGB_W  = 29;
	localparam int SKIP_W  = 28;

	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [7:0] SYNC_MASK   = 8'hF6;
	localparam logic [7:0] SYNC_VAL    = 8'hF0;
	localparam logic [7:0] RATE_MASK   = 8'h3C;
	localparam logic [7:0] LEN_HI_MASK = 8'h03;

	localparam int MARK_W = 8 * WIN_DEPTH;
	localparam logic [MARK_W-1:0] MK_ID3 = {"ID3", 64'h0};
	localparam logic [MARK_W-1:0] MK_TAG = {"TAG", 64'h0};
	localparam logic [MARK_W-1:0] MK_APE = {"APETAGEX", 24'h0};
	localparam logic [MARK_W-1:0] MK_LYR = "LYRICSBEGIN";
	localparam int MK_ID3_LEN = 3;
	localparam int MK_TAG_LEN = 3;
	localparam int MK_APE_LEN = 8;
	localparam int MK_LYR_LEN = 11;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;
	localparam int RQ_CW    = 3;

	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_TAGSKIP,
		PH_SYNC,
		PH_BOUND,
		PH_HUNT,
		PH_FRAME,
		PH_NOTADTS,
		PH_TRAILER
	} phase_t;

	typedef enum logic [1:0] {
		MT_NONE,
		MT_PART,
		MT_FULL
	} mt_t;

	typedef enum logic [1:0] {
		ST_CLEAN,
		ST_TRAILER,
		ST_TRUNC,
		ST_NOTADTS
	} st_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [LEN_W-1:0]   frame_length;
		logic [FCNT_W-1:0]  frame_count;
		logic [RATE_W-1:0]  rate_code;
		logic [SRATE_W-1:0] sample_rate;
		st_t                status;
		logic [TAGB_W-1:0]  tag_bytes;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

	function automatic logic [SRATE_W-1:0] rate_hz(logic [RATE_W-1:0] rc);
		logic [SRATE_W-1:0] hz;
		case (rc)
			4'd0:    hz = 17'd96000;
			4'd1:    hz = 17'd88200;
			4'd2:    hz = 17'd64000;
			4'd3:    hz = 17'd48000;
			4'd4:    hz = 17'd44100;
			4'd5:    hz = 17'd32000;
			4'd6:    hz = 17'd24000;
			4'd7:    hz = 17'd22050;
			4'd8:    hz = 17'd16000;
			4'd9:    hz = 17'd12000;
			4'd10:   hz = 17'd11025;
			4'd11:   hz = 17'd8000;
			4'd12:   hz = 17'd7350;
			default: hz = 17'd0;
		endcase
		return hz;
	endfunction

endpackage

// ===== rtl/core/adts_scan.sv =====
// Byte scanner: tag skip, sync check, header hunt, frame skip and trailer stop.
// Depends on adts_pkg and assert_macros.svh; feeds result requests to adts_rqueue.
`include "assert_macros.svh"

module adts_scan #(
	parameter int COUNT_BITS = adts_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  adts_pkg::item_t      in_item,
	output adts_pkg::res_pair_t  res
);
	import adts_pkg::*;

	function automatic mt_t match_mark(win_t w, logic [FILL_W-1:0] f,
			logic [MARK_W-1:0] m, int len);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (i < len && i < int'(f) && w[i] != m[MARK_W-1-8*i -: 8])
				ok = 1'b0;
		end
		if (!ok)
			return MT_NONE;
		return (int'(f) >= len) ? MT_FULL : MT_PART;
	endfunction

	function automatic mt_t trailer(win_t w, logic [FILL_W-1:0] f);
		mt_t a;
		mt_t b;
		mt_t c;
		a = match_mark(w, f, MK_TAG, MK_TAG_LEN);
		b = match_mark(w, f, MK_APE, MK_APE_LEN);
		c = match_mark(w, f, MK_LYR, MK_LYR_LEN);
		if (a == MT_FULL || b == MT_FULL || c == MT_FULL)
			return MT_FULL;
		if (a == MT_PART || b == MT_PART || c == MT_PART)
			return MT_PART;
		return MT_NONE;
	endfunction

	function automatic logic [FILL_W-1:0] first_ff(win_t w, logic [FILL_W-1:0] f,
			logic [FILL_W-1:0] start);
		logic [FILL_W-1:0] p;
		p = f;
		for (int i = WIN_DEPTH - 1; i >= 0; i--) begin
			if (i >= int'(start) && i < int'(f) && w[i] == SYNC_BYTE)
				p = FILL_W'(i);
		end
		return p;
	endfunction

	phase_t                phase_q, phase_d;
	win_t                  win_q, win_d, wp, left_w;
	logic [FILL_W-1:0]     fill_q, fill_d, fillp, drop_p, left_f, left_p;
	logic [SKIP_W-1:0]     skip_q, skip_d, tag_size;
	logic [LEN_W-1:0]      fleft_q, fleft_d, clen_q, clen_d, hdr_len;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic [RATE_W-1:0]     frate_q, frate_d;
	logic                  rseen_q, rseen_d;
	logic [TAGB_W-1:0]     tag_q, tag_d;
	logic                  frame_done, do_sync, hdr_ok, sync_ok;
	mt_t                   id3_mt, bound_mt, left_mt;
	st_t                   st;
	logic                  eos_v;

	assign eos_v = in_valid && in_item.eos;

	always_comb begin
		phase_d    = phase_q;
		win_d      = win_q;
		fill_d     = fill_q;
		skip_d     = skip_q;
		fleft_d    = fleft_q;
		clen_d     = clen_q;
		cnt_d      = cnt_q;
		frate_d    = frate_q;
		rseen_d    = rseen_q;
		tag_d      = tag_q;
		frame_done = 1'b0;
		do_sync    = 1'b0;

		wp         = win_q;
		wp[fill_q] = in_item.data;
		fillp      = fill_q + 4'd1;

		cnt_inc  = (&cnt_q) ? cnt_q : COUNT_BITS'(cnt_q + 1'b1);
		tag_size = {wp[6][6:0], wp[7][6:0], wp[8][6:0], wp[9][6:0]};
		hdr_len  = {wp[3][1:0] & LEN_HI_MASK[1:0], wp[4], wp[5][7:5]};
		hdr_ok   = ((wp[1] & SYNC_MASK) == SYNC_VAL) && (hdr_len != '0);
		sync_ok  = (wp[0] == SYNC_BYTE) && ((wp[1] & SYNC_MASK) == SYNC_VAL);
		drop_p   = first_ff(wp, FILL_W'(HDR_BYTES), 4'd1);
		left_w   = wp >> {hdr_len[3:0], 3'b000};
		left_f   = FILL_W'(HDR_BYTES) - hdr_len[3:0];
		left_mt  = trailer(left_w, left_f);
		left_p   = first_ff(left_w, left_f, 4'd0);
		id3_mt   = match_mark(wp, fillp, MK_ID3, MK_ID3_LEN);
		bound_mt = trailer(wp, fillp);

		if (in_valid) begin
			unique case (phase_q)
				PH_TAG: begin
					if (id3_mt == MT_NONE) begin
						do_sync = 1'b1;
					end else if (fillp < FILL_W'(TAG_HDR_BYTES)) begin
						win_d  = wp;
						fill_d = fillp;
					end else begin
						skip_d  = tag_size;
						tag_d   = TAGB_W'(tag_size) + TAGB_W'(TAG_HDR_BYTES);
						fill_d  = '0;
						phase_d = (tag_size != '0) ? PH_TAGSKIP : PH_SYNC;
					end
				end
				PH_TAGSKIP: begin
					if (skip_q <= SKIP_W'(1)) begin
						skip_d  = '0;
						phase_d = PH_SYNC;
					end else begin
						skip_d = skip_q - 1'b1;
					end
				end
				PH_SYNC: begin
					do_sync = 1'b1;
				end
				PH_BOUND: begin
					case (bound_mt)
						MT_FULL: begin
							phase_d = PH_TRAILER;
							fill_d  = '0;
						end
						MT_PART: begin
							win_d  = wp;
							fill_d = fillp;
						end
						default: begin
							phase_d  = PH_HUNT;
							win_d    = wp;
							win_d[0] = in_item.data;
							fill_d   = (in_item.data == SYNC_BYTE) ? 4'd1 : 4'd0;
						end
					endcase
				end
				PH_HUNT: begin
					if (fill_q == '0 && in_item.data != SYNC_BYTE) begin
						fill_d = '0;
					end else if (fillp < FILL_W'(HDR_BYTES)) begin
						win_d  = wp;
						fill_d = fillp;
					end else if (!hdr_ok) begin
						win_d  = wp >> {drop_p, 3'b000};
						fill_d = FILL_W'(HDR_BYTES) - drop_p;
					end else begin
						if (!rseen_q) begin
							rseen_d = 1'b1;
							frate_d = RATE_W'((wp[2] & RATE_MASK) >> 2);
						end
						clen_d = hdr_len;
						if (hdr_len <= LEN_W'(HDR_BYTES)) begin
							frame_done = 1'b1;
							cnt_d      = cnt_inc;
							case (left_mt)
								MT_FULL: begin
									phase_d = PH_TRAILER;
									fill_d  = '0;
								end
								MT_PART: begin
									phase_d = PH_BOUND;
									win_d   = left_w;
									fill_d  = left_f;
								end
								default: begin
									phase_d = PH_HUNT;
									win_d   = left_w >> {left_p, 3'b000};
									fill_d  = left_f - left_p;
								end
							endcase
						end else begin
							fleft_d = hdr_len - LEN_W'(HDR_BYTES);
							fill_d  = '0;
							phase_d = PH_FRAME;
						end
					end
				end
				PH_FRAME: begin
					if (fleft_q <= LEN_W'(1)) begin
						fleft_d    = '0;
						frame_done = 1'b1;
						cnt_d      = cnt_inc;
						fill_d     = '0;
						phase_d    = PH_BOUND;
					end else begin
						fleft_d = fleft_q - 1'b1;
					end
				end
				PH_NOTADTS, PH_TRAILER: begin
				end
				default: begin
				end
			endcase

			if (do_sync) begin
				if (fillp < 4'd2) begin
					phase_d = PH_SYNC;
					win_d   = wp;
					fill_d  = fillp;
				end else if (sync_ok) begin
					phase_d = PH_HUNT;
					win_d   = wp;
					fill_d  = fillp;
				end else begin
					phase_d = PH_NOTADTS;
					fill_d  = '0;
				end
			end
		end
	end

	always_comb begin
		logic [31:0]        cnt_ext;
		logic [RATE_W-1:0]  rc;
		res_t               frm_r;
		res_t               sum_r;
		unique case (phase_d) inside
			PH_TRAILER:         st = ST_TRAILER;
			PH_FRAME:           st = ST_TRUNC;
			PH_BOUND, PH_HUNT:  st = ST_CLEAN;
			default:            st = ST_NOTADTS;
		endcase
		cnt_ext = 32'(cnt_d);
		rc      = rseen_d ? frate_d : '0;

		frm_r.kind         = KIND_FRAME;
		frm_r.frame_length = clen_d;
		frm_r.frame_count  = cnt_ext[FCNT_W-1:0];
		frm_r.rate_code    = rc;
		frm_r.sample_rate  = rseen_d ? rate_hz(rc) : '0;
		frm_r.status       = ST_CLEAN;
		frm_r.tag_bytes    = tag_d;
		frm_r.last         = !eos_v;

		sum_r              = frm_r;
		sum_r.kind         = KIND_SUMMARY;
		sum_r.frame_length = '0;
		sum_r.status       = st;
		sum_r.last         = 1'b1;

		res.n  = 2'(frame_done) + 2'(eos_v);
		res.r0 = frame_done ? frm_r : sum_r;
		res.r1 = sum_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			fill_q  <= '0;
			skip_q  <= '0;
			fleft_q <= '0;
			clen_q  <= '0;
			cnt_q   <= '0;
			frate_q <= '0;
			rseen_q <= 1'b0;
			tag_q   <= '0;
		end else if (eos_v) begin
			phase_q <= PH_TAG;
			fill_q  <= '0;
			skip_q  <= '0;
			fleft_q <= '0;
			clen_q  <= '0;
			cnt_q   <= '0;
			frate_q <= '0;
			rseen_q <= 1'b0;
			tag_q   <= '0;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			skip_q  <= skip_d;
			fleft_q <= fleft_d;
			clen_q  <= clen_d;
			cnt_q   <= cnt_d;
			frate_q <= frate_d;
			rseen_q <= rseen_d;
			tag_q   <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	`ADTS_ASSERT_IMP(a_hunt_fill, clk, arst_n, phase_q == PH_HUNT, fill_q < FILL_W'(HDR_BYTES))
	`ADTS_ASSERT_IMP(a_frame_src, clk, arst_n, frame_done, phase_q == PH_HUNT || phase_q == PH_FRAME)
	`ADTS_ASSERT_NEXT(a_eos_clear, clk, arst_n, eos_v, phase_q == PH_TAG && cnt_q == '0)

endmodule

// ===== rtl/core/adts_rqueue.sv =====
// Result queue: takes up to two result requests a cycle, hands out one.
// Depends on adts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module adts_rqueue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  adts_pkg::res_pair_t      wr,
	input  logic                     pop,
	output adts_pkg::res_t           head,
	output logic                     nonempty,
	output logic [adts_pkg::RQ_CW-1:0] count
);
	import adts_pkg::*;

	res_t             mem [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_q, rd_q;
	logic [RQ_CW-1:0] cnt_q;
	logic             do_pop;

	assign do_pop   = pop && (cnt_q != '0);
	assign nonempty = (cnt_q != '0);
	assign head     = mem[rd_q];
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0)
			mem[wr_q] <= wr.r0;
		if (wr.n == 2'd2)
			mem[RQ_AW'(wr_q + 1'b1)] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= RQ_AW'(wr_q + wr.n);
			rd_q  <= RQ_AW'(rd_q + do_pop);
			cnt_q <= RQ_CW'(cnt_q + wr.n - do_pop);
		end
	end

	`ADTS_ASSERT_IMP(a_room, clk, arst_n, wr.n != 2'd0, (RQ_CW'(cnt_q) + RQ_CW'(wr.n)) <= RQ_CW'(RQ_DEPTH))

endmodule

// ===== rtl/core/adts_frame_scanner_top.sv =====
// ADTS frame scanner, one file byte per cycle while in_ready is high. An accepted byte is
// held in the byte register, which feeds the scan logic that writes the result queue.
// in_ready drops while the queued results, plus two for a byte in the byte register, would
// exceed two of the four queue entries. arst_n clears the scan state to the tag check and
// empties the queue; an end-of-stream byte returns the scan state to that same point.
// Depends on adts_pkg, adts_scan and adts_rqueue.
module adts_frame_scanner_top #(
	parameter int COUNT_BITS = adts_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [adts_pkg::LEN_W-1:0]    frame_length,
	output logic [adts_pkg::FCNT_W-1:0]   frame_count,
	output logic [adts_pkg::RATE_W-1:0]   rate_code,
	output logic [adts_pkg::SRATE_W-1:0]  sample_rate,
	output logic [1:0]                    status,
	output logic [adts_pkg::TAGB_W-1:0]   tag_bytes,
	output logic                          last
);
	import adts_pkg::*;

	item_t            item_s1;
	logic             v_s1;
	res_pair_t        pair;
	res_t             head;
	logic [RQ_CW-1:0] q_cnt;
	logic [RQ_CW:0]   need;
	logic             accept;

	assign need     = {1'b0, q_cnt} + (v_s1 ? (RQ_CW+1)'(2) : '0);
	assign in_ready = need <= (RQ_CW+1)'(RQ_DEPTH - 2);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data <= data_byte;
			item_s1.eos  <= end_of_stream;
		end
	end

	adts_scan #(
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_item  (item_s1),
		.res      (pair)
	);

	adts_rqueue u_rqueue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (pair),
		.pop      (out_ready),
		.head     (head),
		.nonempty (out_valid),
		.count    (q_cnt)
	);

	assign kind         = head.kind;
	assign frame_length = head.frame_length;
	assign frame_count  = head.frame_count;
	assign rate_code    = head.rate_code;
	assign sample_rate  = head.sample_rate;
	assign status       = head.status;
	assign tag_bytes    = head.tag_bytes;
	assign last         = head.last;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for adts_frame_scanner_top: builds audio files byte by byte, runs
// each byte through a scan model of its own and checks every frame and summary result.
// Depends on adts_pkg and the scanner RTL.
module testbench;
	import adts_pkg::*;

	localparam int CNT_MAX = (1 << COUNT_BITS_DEF) - 1;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic end_of_stream = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [LEN_W-1:0] frame_length;
	logic [FCNT_W-1:0] frame_count;
	logic [RATE_W-1:0] rate_code;
	logic [SRATE_W-1:0] sample_rate;
	logic [1:0] status;
	logic [TAGB_W-1:0] tag_bytes;
	logic last;

	adts_frame_scanner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.frame_length(frame_length),
		.frame_count(frame_count),
		.rate_code(rate_code),
		.sample_rate(sample_rate),
		.status(status),
		.tag_bytes(tag_bytes),
		.last(last)
	);

	logic [SRATE_W-1:0] hz_by_code [16] = '{96000, 88200, 64000, 48000, 44100, 32000,
		24000, 22050, 16000, 12000, 11025, 8000, 7350, 0, 0, 0};

	// scan model state
	logic [7:0] win [WIN_DEPTH];
	int win_fill;
	phase_t scan_ph;
	logic [TAGB_W-1:0] tag_skip_left;
	logic [LEN_W-1:0] frame_rem;
	logic [LEN_W-1:0] frame_len;
	logic [FCNT_W-1:0] frames_done;
	logic [RATE_W-1:0] first_code;
	logic code_seen;
	logic [TAGB_W-1:0] tag_len;
	logic scan_stopped;

	res_t step_results[$];
	res_t results_due[$];
	res_t head;
	logic [7:0] file_q[$];

	int send_idle;
	int recv_idle;
	int errors = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int frames_seen = 0;
	int summaries_seen = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void clear_scan();
		for (int i = 0; i < WIN_DEPTH; i++)
			win[i] = 8'h00;
		win_fill = 0;
		scan_ph = PH_TAG;
		tag_skip_left = '0;
		frame_rem = '0;
		frame_len = '0;
		frames_done = '0;
		first_code = '0;
		code_seen = 1'b0;
		tag_len = '0;
		scan_stopped = 1'b0;
	endfunction

	function automatic void shift_win(int n);
		if (n >= win_fill) begin
			win_fill = 0;
		end else begin
			for (int i = 0; i < win_fill - n; i++)
				win[i] = win[i + n];
			win_fill -= n;
		end
	endfunction

	function automatic mt_t mark_match(logic [MARK_W-1:0] m, int len);
		int k;
		k = (win_fill < len) ? win_fill : len;
		for (int i = 0; i < k; i++)
			if (win[i] != m[MARK_W-1-8*i -: 8])
				return MT_NONE;
		return (win_fill >= len) ? MT_FULL : MT_PART;
	endfunction

	function automatic void post_result(logic kd, logic [LEN_W-1:0] len, st_t st);
		res_t r;
		r.kind = kd;
		r.frame_length = len;
		r.frame_count = frames_done;
		r.rate_code = code_seen ? first_code : '0;
		r.sample_rate = code_seen ? hz_by_code[first_code] : '0;
		r.status = st;
		r.tag_bytes = tag_len;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void count_frame();
		if (frames_done < CNT_MAX)
			frames_done++;
		post_result(KIND_FRAME, frame_len, ST_CLEAN);
	endfunction

	function automatic void settle();
		mt_t a, b, c;
		logic [LEN_W-1:0] len;
		for (int guard = 0; guard < 64; guard++) begin
			if (scan_ph == PH_TAG) begin
				if (mark_match(MK_ID3, MK_ID3_LEN) == MT_NONE) begin
					scan_ph = PH_SYNC;
					continue;
				end
				if (win_fill < TAG_HDR_BYTES)
					return;
				tag_skip_left = {1'b0, win[6][6:0], win[7][6:0], win[8][6:0], win[9][6:0]};
				tag_len = tag_skip_left + TAG_HDR_BYTES;
				win_fill = 0;
				scan_ph = (tag_skip_left != 0) ? PH_TAGSKIP : PH_SYNC;
				return;
			end else if (scan_ph == PH_SYNC) begin
				if (win_fill < 2)
					return;
				if (win[0] == SYNC_BYTE && (win[1] & SYNC_MASK) == SYNC_VAL) begin
					scan_ph = PH_BOUND;
					continue;
				end
				scan_ph = PH_NOTADTS;
				scan_stopped = 1'b1;
				return;
			end else if (scan_ph == PH_BOUND) begin
				if (win_fill == 0)
					return;
				a = mark_match(MK_TAG, MK_TAG_LEN);
				b = mark_match(MK_APE, MK_APE_LEN);
				c = mark_match(MK_LYR, MK_LYR_LEN);
				if (a == MT_FULL || b == MT_FULL || c == MT_FULL) begin
					scan_ph = PH_TRAILER;
					scan_stopped = 1'b1;
					win_fill = 0;
					return;
				end
				if (a == MT_PART || b == MT_PART || c == MT_PART)
					return;
				scan_ph = PH_HUNT;
			end else if (scan_ph == PH_HUNT) begin
				while (win_fill > 0 && win[0] != SYNC_BYTE)
					shift_win(1);
				if (win_fill < HDR_BYTES)
					return;
				len = {win[3][1:0], win[4], win[5][7:5]};
				if ((win[1] & SYNC_MASK) != SYNC_VAL || len == 0) begin
					shift_win(1);
					continue;
				end
				if (!code_seen) begin
					first_code = win[2][5:2];
					code_seen = 1'b1;
				end
				frame_len = len;
				if (len <= win_fill) begin
					shift_win(len);
					count_frame();
					scan_ph = PH_BOUND;
					continue;
				end
				frame_rem = len - win_fill;
				win_fill = 0;
				scan_ph = PH_FRAME;
				return;
			end else begin
				return;
			end
		end
	endfunction

	function automatic void push_win(logic [7:0] b);
		if (win_fill >= WIN_DEPTH)
			shift_win(1);
		win[win_fill] = b;
		win_fill++;
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic eos);
		st_t st;
		res_t r;
		step_results.delete();
		if (scan_ph == PH_TAGSKIP) begin
			if (tag_skip_left == 0) begin
				scan_ph = PH_SYNC;
				push_win(b);
				settle();
			end else begin
				tag_skip_left--;
				if (tag_skip_left == 0)
					scan_ph = PH_SYNC;
			end
		end else if (scan_ph == PH_FRAME) begin
			if (frame_rem > 0)
				frame_rem--;
			if (frame_rem == 0) begin
				count_frame();
				scan_ph = PH_BOUND;
			end
		end else if (!scan_stopped) begin
			push_win(b);
			settle();
		end
		if (eos) begin
			if (scan_ph == PH_TRAILER)
				st = ST_TRAILER;
			else if (scan_ph == PH_FRAME)
				st = ST_TRUNC;
			else if (scan_ph == PH_BOUND || scan_ph == PH_HUNT)
				st = ST_CLEAN;
			else
				st = ST_NOTADTS;
			post_result(KIND_SUMMARY, '0, st);
			clear_scan();
		end
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.push_back(r);
		end
		foreach (step_results[i])
			results_due.push_back(step_results[i]);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result with none expected, got kind %0d length %0d status %0d",
					$time, kind, frame_length, status);
				errors++;
			end else begin
				head = results_due.pop_front();
				check_field("kind", head.kind, kind);
				check_field("frame_length", head.frame_length, frame_length);
				check_field("frame_count", head.frame_count, frame_count);
				check_field("rate_code", head.rate_code, rate_code);
				check_field("sample_rate", head.sample_rate, sample_rate);
				check_field("status", head.status, status);
				check_field("tag_bytes", head.tag_bytes, tag_bytes);
				check_field("last", head.last, last);
				if (head.kind == KIND_SUMMARY)
					summaries_seen++;
				else
					frames_seen++;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		// hold the request until it is taken
		do @(posedge clk); while (!in_ready);
		predict_byte(b, eos);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == file_q.size() - 1);
		files_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	function automatic void put_mark(logic [MARK_W-1:0] m, int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(m[MARK_W-1-8*i -: 8]);
	endfunction

	function automatic void put_random(int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(8'($urandom));
	endfunction

	function automatic void put_tag(int size, int body);
		put_mark(MK_ID3, MK_ID3_LEN);
		put_random(3);
		file_q.push_back({1'($urandom), 7'(size >> 21)});
		file_q.push_back({1'($urandom), 7'(size >> 14)});
		file_q.push_back({1'($urandom), 7'(size >> 7)});
		file_q.push_back({1'($urandom), 7'(size)});
		put_random(body);
	endfunction

	function automatic void put_header(int len, int code);
		file_q.push_back(SYNC_BYTE);
		file_q.push_back(SYNC_VAL | (8'($urandom) & ~SYNC_MASK));
		file_q.push_back({2'($urandom), 4'(code), 2'($urandom)});
		file_q.push_back({6'($urandom), 2'(len >> 11)});
		file_q.push_back(8'(len >> 3));
		file_q.push_back({3'(len), 5'($urandom)});
		put_random(2);
	endfunction

	function automatic void put_frame(int len, int code);
		put_header(len, code);
		if (len > HDR_BYTES)
			put_random(len - HDR_BYTES);
	endfunction

	function automatic void put_bad_header(bit zero_len);
		if (zero_len) begin
			put_header(0, $urandom_range(15));
		end else begin
			file_q.push_back(SYNC_BYTE);
			file_q.push_back(8'($urandom) | 8'h02);
			put_random(6);
		end
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return $urandom_range(1, HDR_BYTES);
		if (r < 95)
			return $urandom_range(HDR_BYTES + 1, 48);
		return $urandom_range(49, 400);
	endfunction

	function automatic void make_file();
		int code, len;
		file_q.delete();
		code = $urandom_range(15);
		if ($urandom_range(2) == 0)
			put_tag($urandom_range(24), 0);
		if (file_q.size() > 0)
			put_random(file_q[9] & 8'h7F);
		if ($urandom_range(11) == 0)
			put_random($urandom_range(1, 6));
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(7) == 0) begin
				if ($urandom_range(1) == 0)
					put_random($urandom_range(1, 12));
				else
					put_bad_header($urandom_range(1));
			end
			put_frame(pick_len(), ($urandom_range(9) == 0) ? $urandom_range(15) : code);
		end
		case ($urandom_range(9))
			0: begin
				put_mark(MK_TAG, MK_TAG_LEN);
				put_random($urandom_range(5));
			end
			1: begin
				put_mark(MK_APE, MK_APE_LEN);
				put_random($urandom_range(5));
			end
			2: put_mark(MK_LYR, MK_LYR_LEN);
			3: put_mark(MK_LYR, $urandom_range(1, MK_LYR_LEN - 1));
			4: put_mark(MK_APE, $urandom_range(1, MK_APE_LEN - 1));
			5, 6: begin
				len = $urandom_range(HDR_BYTES + 1, 60);
				put_header(len, code);
				put_random($urandom_range(len - HDR_BYTES - 1));
			end
			default: ;
		endcase
	endfunction

	function automatic void make_noise();
		file_q.delete();
		if ($urandom_range(1) == 0) begin
			file_q.push_back(SYNC_BYTE);
			file_q.push_back(SYNC_VAL);
		end
		put_random($urandom_range(1, 30));
	endfunction

	task automatic test_sync_check();
		file_q = '{8'h00, 8'h11};
		send_file();
		file_q = '{SYNC_BYTE, 8'hF6};
		send_file();
		file_q = '{SYNC_BYTE};
		send_file();
		file_q.delete();
		put_header(HDR_BYTES + 1, 4);
		file_q[1] = 8'hF9;
		file_q.push_back(8'hA5);
		send_file();
	endtask

	task automatic test_tag_skip();
		file_q.delete();
		put_tag(0, 0);
		put_frame(12, 3);
		send_file();
		file_q.delete();
		put_tag(133, 133);
		put_frame(10, 6);
		send_file();
		file_q.delete();
		put_tag(28'hFFFFFFF, 3);
		send_file();
		file_q.delete();
		put_mark(MK_ID3, 2);
		send_file();
	endtask

	task automatic test_frame_lengths();
		for (int code = 0; code < 16; code++) begin
			file_q.delete();
			put_frame(HDR_BYTES + 1, code);
			send_file();
		end
		file_q.delete();
		put_frame(1, 11);
		put_frame(HDR_BYTES, 2);
		put_bad_header(1'b1);
		put_bad_header(1'b0);
		put_frame(8191, 5);
		put_frame(20, 7);
		send_file();
	endtask

	task automatic test_trailers();
		file_q.delete();
		put_frame(16, 3);
		put_mark(MK_TAG, MK_TAG_LEN);
		put_random(4);
		send_file();
		file_q.delete();
		put_frame(16, 3);
		put_mark(MK_APE, MK_APE_LEN);
		put_random(2);
		send_file();
		file_q.delete();
		put_frame(16, 3);
		put_mark(MK_LYR, MK_LYR_LEN);
		send_file();
		file_q.delete();
		put_frame(16, 3);
		put_mark(MK_LYR, MK_LYR_LEN - 1);
		send_file();
		file_q.delete();
		put_frame(16, 3);
		put_mark(MK_TAG, 2);
		put_frame(12, 8);
		send_file();
	endtask

	task automatic test_early_end();
		file_q.delete();
		put_frame(14, 1);
		put_header(30, 1);
		put_random(3);
		send_file();
		file_q.delete();
		put_frame(14, 1);
		file_q.push_back(8'h00);
		file_q.push_back(8'h12);
		send_file();
		file_q.delete();
		put_frame(14, 1);
		put_frame(9, 1);
		send_file();
	endtask

	task automatic test_random_files(input int target);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			if ($urandom_range(9) == 0)
				make_noise();
			else
				make_file();
			send_file();
		end
	endtask

	initial begin
		clear_scan();
		send_idle = 24;
		recv_idle = 84;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sync_check();
		test_tag_skip();
		test_frame_lengths();
		test_trailers();
		test_early_end();
		test_random_files(700);
		wait_drained();
		send_idle = 84;
		recv_idle = 24;
		test_random_files(700);
		send_idle = 0;
		recv_idle = 0;
		test_random_files(700);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Scanned %0d files, %0d bytes; checked %0d frame results and %0d summaries",
			files_sent, bytes_sent, frames_seen, summaries_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
